// File: hw/rtl/mse_pkg.sv
// Shared types and constants for the merge sort engine.
// No dependencies; compile first.
`default_nettype none

package mse_pkg;

	// Width of the value fields on both item channels.
	localparam int unsigned VALUE_W = 32;

	// Per-cycle commands from the sequencer to the buffer datapath.
	typedef struct packed {
		logic wr_en;        // write one buffer entry this cycle
		logic wr_b;         // write buffer B (else buffer A)
		logic wr_from_in;   // write data comes from the input item
		logic wr_from_left; // merge write takes the left head (else right head)
		logic rd_en;        // update both read registers
		logic rd_b;         // read from buffer B (else buffer A)
	} mse_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mse_if.sv
// Valid/ready item channels for the merge sort engine input and output.
// Depends on mse_pkg for the value width.
`default_nettype none

interface mse_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [mse_pkg::VALUE_W-1:0]     in_value;
	logic                                   in_last;

	modport source (output valid, output in_value, output in_last, input ready);
	modport sink (input valid, input in_value, input in_last, output ready);
endinterface

interface mse_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [mse_pkg::VALUE_W-1:0]     out_value;
	logic                                   out_last;

	modport source (output valid, output out_value, output out_last, input ready);
	modport sink (input valid, input out_value, input out_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mse_dpath.sv
// Ping-pong buffers, head read registers and the shared compare unit.
// Depends on mse_pkg for the command struct and value width.
`default_nettype none

module mse_dpath #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                              clk,
	input  wire mse_pkg::mse_ctrl_t                ctrl,
	input  wire logic [AW-1:0]                     wr_addr,
	input  wire logic [AW-1:0]                     rd_addr_l,
	input  wire logic [AW-1:0]                     rd_addr_r,
	input  wire logic signed [mse_pkg::VALUE_W-1:0] in_value,
	output logic [DATA_WIDTH-1:0]                  rd_l,
	output logic                                   le
);

	logic [DATA_WIDTH-1:0] mem_a [DEPTH];
	logic [DATA_WIDTH-1:0] mem_b [DEPTH];
	logic [DATA_WIDTH-1:0] ra_q;
	logic [DATA_WIDTH-1:0] rb_q;
	logic [DATA_WIDTH-1:0] in_ext;
	logic [DATA_WIDTH-1:0] wdata;

	// Sign-extend or truncate the incoming value to the stored width.
	assign in_ext = DATA_WIDTH'(in_value);

	always_comb begin
		if (ctrl.wr_from_in) begin
			wdata = in_ext;
		end else if (ctrl.wr_from_left) begin
			wdata = ra_q;
		end else begin
			wdata = rb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && !ctrl.wr_b) begin
			mem_a[wr_addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && ctrl.wr_b) begin
			mem_b[wr_addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			ra_q <= ctrl.rd_b ? mem_b[rd_addr_l] : mem_a[rd_addr_l];
			rb_q <= ctrl.rd_b ? mem_b[rd_addr_r] : mem_a[rd_addr_r];
		end
	end

	// Ties go left, which keeps the sort stable.
	assign le   = $signed(ra_q) <= $signed(rb_q);
	assign rd_l = ra_q;

endmodule

`default_nettype wire

// File: hw/rtl/mse_seq.sv
// Sequencer: load counter, bottom-up merge pass control and emit read issue.
// Depends on mse_pkg for the command struct; drives mse_dpath.
`default_nettype none

module mse_seq #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW   = $clog2(DEPTH + 1),
	localparam int unsigned WW   = CW + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic               in_last,
	input  wire logic               le,
	input  wire logic               take,
	output logic                    in_ready,
	output mse_pkg::mse_ctrl_t      ctrl,
	output logic [AW-1:0]           wr_addr,
	output logic [AW-1:0]           rd_addr_l,
	output logic [AW-1:0]           rd_addr_r,
	output logic                    pend,
	output logic                    pend_last
);

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_PRIME = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] e_q;
	logic [WW-1:0] width_q;
	logic [WW-1:0] lo_q;
	logic [WW-1:0] mid_q;
	logic [WW-1:0] hi_q;
	logic [WW-1:0] i_q;
	logic [WW-1:0] j_q;
	logic [WW-1:0] k_q;
	logic          src_b_q;
	logic          pend_q;
	logic          pend_last_q;

	logic          room;
	logic [CW-1:0] n_nx;
	logic [WW-1:0] n_w;
	logic [WW-1:0] mid_c;
	logic [WW-1:0] hi_c;
	logic [WW-1:0] width_2x;
	logic [WW-1:0] i_nx;
	logic [WW-1:0] j_nx;
	logic          take_left;
	logic          run_end;
	logic          prime_go;
	logic          rd_issue;
	logic          emit_end;

	assign room     = fill_q < CW'(DEPTH);
	assign n_nx     = fill_q + CW'(room);
	assign n_w      = WW'(n_q);
	assign mid_c    = ((lo_q + width_q) < n_w) ? (lo_q + width_q) : n_w;
	assign hi_c     = ((mid_c + width_q) < n_w) ? (mid_c + width_q) : n_w;
	assign width_2x = width_q << 1;

	assign take_left = (i_q < mid_q) && ((j_q >= hi_q) || le);
	assign i_nx      = i_q + WW'(take_left);
	assign j_nx      = j_q + WW'(!take_left);
	assign run_end   = k_q == (hi_q - WW'(1));

	// Hold priming until the emit read register of the previous set is consumed.
	assign prime_go = (state_q == ST_PRIME) && !pend_q;
	assign rd_issue = (state_q == ST_EMIT) && (e_q < n_q) && (!pend_q || take);
	assign emit_end = rd_issue && (e_q == (n_q - CW'(1)));

	assign in_ready  = state_q == ST_LOAD;
	assign pend      = pend_q;
	assign pend_last = pend_last_q;

	always_comb begin
		ctrl      = '0;
		wr_addr   = fill_q[AW-1:0];
		rd_addr_l = e_q[AW-1:0];
		rd_addr_r = e_q[AW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				ctrl.wr_en      = in_fire && room;
				ctrl.wr_from_in = 1'b1;
			end
			ST_PRIME: begin
				ctrl.rd_en = prime_go;
				ctrl.rd_b  = src_b_q;
				rd_addr_l  = lo_q[AW-1:0];
				rd_addr_r  = mid_c[AW-1:0];
			end
			ST_MERGE: begin
				ctrl.wr_en        = 1'b1;
				ctrl.wr_b         = !src_b_q;
				ctrl.wr_from_left = take_left;
				ctrl.rd_en        = 1'b1;
				ctrl.rd_b         = src_b_q;
				wr_addr           = k_q[AW-1:0];
				rd_addr_l         = i_nx[AW-1:0];
				rd_addr_r         = j_nx[AW-1:0];
			end
			ST_EMIT: begin
				ctrl.rd_en = rd_issue;
				ctrl.rd_b  = src_b_q;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			n_q         <= '0;
			e_q         <= '0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			src_b_q     <= 1'b0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (rd_issue) begin
				pend_q      <= 1'b1;
				pend_last_q <= e_q == (n_q - CW'(1));
			end else if (take) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (in_last) begin
							n_q     <= n_nx;
							fill_q  <= '0;
							width_q <= WW'(1);
							lo_q    <= '0;
							src_b_q <= 1'b0;
							e_q     <= '0;
							state_q <= (n_nx > CW'(1)) ? ST_PRIME : ST_EMIT;
						end else begin
							fill_q <= n_nx;
						end
					end
				end
				ST_PRIME: begin
					if (prime_go) begin
						mid_q   <= mid_c;
						hi_q    <= hi_c;
						i_q     <= lo_q;
						j_q     <= mid_c;
						k_q     <= lo_q;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					i_q <= i_nx;
					j_q <= j_nx;
					k_q <= k_q + WW'(1);
					if (run_end) begin
						if (hi_q == n_w) begin
							// Pass done: swap buffers, double the run length.
							src_b_q <= !src_b_q;
							width_q <= width_2x;
							lo_q    <= '0;
							if (width_2x >= n_w) begin
								e_q     <= '0;
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_PRIME;
							end
						end else begin
							lo_q    <= hi_q;
							state_q <= ST_PRIME;
						end
					end
				end
				ST_EMIT: begin
					if (rd_issue) begin
						e_q <= e_q + CW'(1);
					end
					if (emit_end) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Every merge write consumes exactly one head.
	a_merge_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |->
			(({1'b0, k_q} + {1'b0, mid_q}) == ({1'b0, i_q} + {1'b0, j_q})))
		else $error("merge output index out of step with head indices");

	a_merge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (k_q < hi_q) && (hi_q <= n_w))
		else $error("merge write beyond run end");

	a_prime_sorts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRIME) |-> (n_q > CW'(1)) && (lo_q < n_w))
		else $error("merge pass started on a trivial set or past its end");

	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (fill_q == '0))
		else $error("fill count not cleared after set end");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (e_q < n_q))
		else $error("emit index beyond set size");

endmodule

`default_nettype wire

// File: hw/rtl/merge_sort_engine_top.sv
// Items not marked last are accepted while loading. On the item marked last
// the set of n entries is sorted by ceil(log2 n) merge passes through the shared
// compare unit, one entry per cycle, each run pair primed before its merge; the
// items then go out one per cycle while the output is ready. The next set is
// accepted only after the last read of the previous set is issued.
// Reset: sequencer and output valid clear; output data and buffers stay undefined.
`default_nettype none

module merge_sort_engine_top #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mse_in_if.sink     in_item,
	mse_out_if.source  out_item
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mse_pkg::mse_ctrl_t                ctrl;
	logic [AW-1:0]                     wr_addr;
	logic [AW-1:0]                     rd_addr_l;
	logic [AW-1:0]                     rd_addr_r;
	logic [DATA_WIDTH-1:0]             rd_l;
	logic                              le;
	logic                              in_ready;
	logic                              pend;
	logic                              pend_last;
	logic                              take;
	logic                              out_valid_q;
	logic signed [mse_pkg::VALUE_W-1:0] out_value_q;
	logic                              out_last_q;

	assign in_item.ready = in_ready;

	// Move the read item into the output register when it is empty or draining.
	assign take = pend && (!out_valid_q || out_item.ready);

	mse_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_item.valid && in_ready),
		.in_last   (in_item.in_last),
		.le        (le),
		.take      (take),
		.in_ready  (in_ready),
		.ctrl      (ctrl),
		.wr_addr   (wr_addr),
		.rd_addr_l (rd_addr_l),
		.rd_addr_r (rd_addr_r),
		.pend      (pend),
		.pend_last (pend_last)
	);

	mse_dpath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.ctrl      (ctrl),
		.wr_addr   (wr_addr),
		.rd_addr_l (rd_addr_l),
		.rd_addr_r (rd_addr_r),
		.in_value  (in_item.in_value),
		.rd_l      (rd_l),
		.le        (le)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_value_q <= mse_pkg::VALUE_W'($signed(rd_l));
			out_last_q  <= pend_last;
		end
	end

	assign out_item.valid     = out_valid_q;
	assign out_item.out_value = out_value_q;
	assign out_item.out_last  = out_last_q;

endmodule

`default_nettype wire
